>>> rtl/dse_pkg.sv
package dse_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	// Index arithmetic is done one bit wider than the count so lo + 2 never wraps.
	localparam int IDX_W = CNT_W + 1;
	localparam int DATA_W = 32;
	localparam int DEPTH_W = 8;
	localparam int ACT_W = 3;
	localparam int TDATA_IN_W = 32;
	localparam int TUSER_IN_W = 4;
	localparam int TDATA_OUT_W = 40;
	localparam int TUSER_OUT_W = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH    = 3'd0,
		ACT_POP     = 3'd1,
		ACT_REVERSE = 3'd2,
		ACT_REMOVE  = 3'd3,
		ACT_COMPARE = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic    load;
		logic    init;
		logic    push_wr;
		logic    rd;
		logic    rd_next;
		logic    wr_lo_b;
		logic    wr_hi_a;
		logic    hi_dec;
		logic    lo_inc;
		logic    mark_pos;
		logic    shift_wr;
		logic    cnt_dec;
		logic    set_pop;
		logic    set_status;
		status_t status;
		logic    set_eq;
		logic    eq;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    full;
		logic    empty;
		logic    shallow;
		logic    cnt_diff;
		logic    cmp_zero;
		logic    match_b;
		logic    hi_zero;
		logic    top_hit;
		logic    rev_more;
		logic    shift_more;
		logic    cmp_diff;
		logic    cmp_last;
		logic    out_free;
	} sts_t;

endpackage

>>> rtl/dse_ctrl.sv
module dse_ctrl
	import dse_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_START = 8'b0000_0010,
		S_RD    = 8'b0000_0100,
		S_EVAL  = 8'b0000_1000,
		S_WR    = 8'b0001_0000,
		S_SRD   = 8'b0010_0000,
		S_SWR   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q, state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_OK;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nxt = S_START;
				end
			end
			S_START: begin
				cmd.init = 1'b1;
				state_nxt = S_DONE;
				case (sts.act)
					ACT_PUSH: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_FULL;
						end else begin
							cmd.push_wr = 1'b1;
						end
					end
					ACT_POP: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_EMPTY;
						end else begin
							state_nxt = S_RD;
						end
					end
					ACT_REVERSE: begin
						if (!sts.shallow) state_nxt = S_RD;
					end
					ACT_REMOVE: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_NOTFOUND;
						end else begin
							state_nxt = S_RD;
						end
					end
					ACT_COMPARE: begin
						if (sts.cnt_diff) begin
							cmd.set_eq = 1'b1;
							cmd.eq = 1'b0;
						end else if (sts.cmp_zero) begin
							cmd.set_eq = 1'b1;
							cmd.eq = 1'b1;
						end else begin
							state_nxt = S_RD;
						end
					end
					default: state_nxt = S_DONE;
				endcase
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_nxt = S_EVAL;
			end
			S_EVAL: begin
				state_nxt = S_DONE;
				case (sts.act)
					ACT_POP: begin
						cmd.set_pop = 1'b1;
						cmd.cnt_dec = 1'b1;
					end
					ACT_REVERSE: begin
						cmd.wr_lo_b = 1'b1;
						state_nxt = S_WR;
					end
					ACT_REMOVE: begin
						if (sts.match_b) begin
							if (sts.top_hit) begin
								cmd.cnt_dec = 1'b1;
							end else begin
								cmd.mark_pos = 1'b1;
								state_nxt = S_SRD;
							end
						end else if (sts.hi_zero) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_NOTFOUND;
						end else begin
							cmd.hi_dec = 1'b1;
							state_nxt = S_RD;
						end
					end
					ACT_COMPARE: begin
						if (sts.cmp_diff) begin
							cmd.set_eq = 1'b1;
							cmd.eq = 1'b0;
						end else if (sts.cmp_last) begin
							cmd.set_eq = 1'b1;
							cmd.eq = 1'b1;
						end else begin
							cmd.lo_inc = 1'b1;
							state_nxt = S_RD;
						end
					end
					default: state_nxt = S_DONE;
				endcase
			end
			S_WR: begin
				cmd.wr_hi_a = 1'b1;
				state_nxt = sts.rev_more ? S_RD : S_DONE;
			end
			S_SRD: begin
				cmd.rd = 1'b1;
				cmd.rd_next = 1'b1;
				state_nxt = S_SWR;
			end
			S_SWR: begin
				cmd.shift_wr = 1'b1;
				if (sts.shift_more) begin
					state_nxt = S_SRD;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

>>> rtl/dse_dp.sv
module dse_dp
	import dse_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic [ACT_W-1:0]       in_action,
	input  logic                   in_sel,
	input  logic [DATA_W-1:0]      in_value,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [DATA_W-1:0]      out_popped,
	output status_t                out_status,
	output logic                   out_equal,
	output logic [DEPTH_W-1:0]     out_depth
);

	logic [DATA_W-1:0] mem0 [STACK_DEPTH];
	logic [DATA_W-1:0] mem1 [STACK_DEPTH];

	action_t           act_q;
	logic              sel_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  cnt0_q, cnt1_q;
	logic [ADDR_W-1:0] lo_q, hi_q;
	logic [DATA_W-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;
	logic [DATA_W-1:0] pop_res_q;
	status_t           status_res_q;
	logic              eq_res_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_popped_q;
	status_t           out_status_q;
	logic              out_equal_q;
	logic [DEPTH_W-1:0] out_depth_q;

	logic [CNT_W-1:0]  n_sel;
	logic [IDX_W-1:0]  lo_w, hi_w, n_w, cnt0_w;
	logic [ADDR_W-1:0] addr_a;
	logic [DATA_W-1:0] rd_a, rd_b;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic              out_free;

	assign n_sel  = sel_q ? cnt1_q : cnt0_q;
	assign lo_w   = IDX_W'(lo_q);
	assign hi_w   = IDX_W'(hi_q);
	assign n_w    = IDX_W'(n_sel);
	assign cnt0_w = IDX_W'(cnt0_q);
	assign addr_a = cmd.rd_next ? (lo_q + ADDR_W'(1)) : lo_q;
	assign rd_a   = sel_q ? rd1a_q : rd0a_q;
	assign rd_b   = sel_q ? rd1b_q : rd0b_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		we = cmd.push_wr | cmd.wr_lo_b | cmd.wr_hi_a | cmd.shift_wr;
		waddr = lo_q;
		wdata = rd_a;
		if (cmd.push_wr) begin
			waddr = n_sel[ADDR_W-1:0];
			wdata = val_q;
		end else if (cmd.wr_lo_b) begin
			waddr = lo_q;
			wdata = rd_b;
		end else if (cmd.wr_hi_a) begin
			waddr = hi_q;
			wdata = rd_a;
		end
	end

	always_comb begin
		sts.act        = act_q;
		sts.full       = (n_sel == CNT_W'(STACK_DEPTH));
		sts.empty      = (n_sel == '0);
		sts.shallow    = (n_sel <= CNT_W'(1));
		sts.cnt_diff   = (cnt0_q != cnt1_q);
		sts.cmp_zero   = (cnt0_q == '0);
		sts.match_b    = (rd_b == val_q);
		sts.hi_zero    = (hi_q == '0);
		sts.top_hit    = (hi_w + IDX_W'(1) == n_w);
		sts.rev_more   = (lo_w + IDX_W'(2) < hi_w);
		sts.shift_more = (lo_w + IDX_W'(2) < n_w);
		sts.cmp_diff   = (rd0a_q != rd1a_q);
		sts.cmp_last   = (lo_w + IDX_W'(1) == cnt0_w);
		sts.out_free   = out_free;
	end

	// Both stores share the address logic; only the selected one is written.
	always_ff @(posedge clk) begin
		if (we && !sel_q) mem0[waddr] <= wdata;
		if (we && sel_q) mem1[waddr] <= wdata;
		if (cmd.rd) begin
			rd0a_q <= mem0[addr_a];
			rd0b_q <= mem0[hi_q];
			rd1a_q <= mem1[addr_a];
			rd1b_q <= mem1[hi_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sel_q <= in_sel;
			val_q <= in_value;
		end
		if (cmd.init) begin
			lo_q <= '0;
			hi_q <= ADDR_W'(n_sel - CNT_W'(1));
		end else begin
			if (cmd.mark_pos) begin
				lo_q <= hi_q;
			end else if (cmd.lo_inc || cmd.wr_hi_a || cmd.shift_wr) begin
				lo_q <= lo_q + ADDR_W'(1);
			end
			if (cmd.hi_dec || cmd.wr_hi_a) hi_q <= hi_q - ADDR_W'(1);
		end
		// A status or compare decided in S_START wins over the clear.
		if (cmd.set_pop) pop_res_q <= rd_b;
		else if (cmd.init) pop_res_q <= '0;
		if (cmd.set_status) status_res_q <= cmd.status;
		else if (cmd.init) status_res_q <= ST_OK;
		if (cmd.set_eq) eq_res_q <= cmd.eq;
		else if (cmd.init) eq_res_q <= 1'b0;
		if (cmd.emit) begin
			out_popped_q <= pop_res_q;
			out_status_q <= status_res_q;
			out_equal_q <= eq_res_q;
			out_depth_q <= (act_q == ACT_COMPARE) ? DEPTH_W'(cnt0_q) : DEPTH_W'(n_sel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_PUSH;
			cnt0_q <= '0;
			cnt1_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) act_q <= action_t'(in_action);
			if (cmd.push_wr) begin
				if (sel_q) cnt1_q <= cnt1_q + CNT_W'(1);
				else cnt0_q <= cnt0_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				if (sel_q) cnt1_q <= cnt1_q - CNT_W'(1);
				else cnt0_q <= cnt0_q - CNT_W'(1);
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_popped = out_popped_q;
	assign out_status = out_status_q;
	assign out_equal  = out_equal_q;
	assign out_depth  = out_depth_q;

endmodule

>>> rtl/dual_stack_engine.sv
// Reverse does n/2 swaps; compare steps entry by entry; remove searches entries from the top down,
// then moves each entry above the match down by one. Push and pop need no walk.
// One item at a time; the next word is taken in the cycle after the result is registered.
// The walk length is set by the single write port of each stack memory.
// Reset (arst_n low) empties both stacks at once; stack memories are not cleared.
// The output register lets a new word enter while the previous result waits.
module dual_stack_engine
	import dse_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,  // [31:0] operand_value
	input  logic [TUSER_IN_W-1:0]  s_tuser,  // [2:0] action, [3] stack_select
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,  // [31:0] popped_value, [39:32] depth_after
	output logic [TUSER_OUT_W-1:0] m_tuser   // [1:0] status, [2] stacks_equal
);

	cmd_t               cmd;
	sts_t               sts;
	logic [DATA_W-1:0]  popped;
	status_t            status;
	logic               equal;
	logic [DEPTH_W-1:0] depth;

	dse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dse_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_action  (s_tuser[2:0]),
		.in_sel     (s_tuser[3]),
		.in_value   (s_tdata[31:0]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_popped (popped),
		.out_status (status),
		.out_equal  (equal),
		.out_depth  (depth)
	);

	assign m_tdata = {depth, popped};
	assign m_tuser = {equal, status};

endmodule

>>> rtl/dse_chk.sv
module dse_chk
	import dse_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [TDATA_IN_W-1:0]  s_tdata,
	input logic [TUSER_IN_W-1:0]  s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_OUT_W-1:0] m_tdata,
	input logic [TUSER_OUT_W-1:0] m_tuser
);

	// A result word waits until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed or dropped while stalled");

	// Only a successful pop carries a value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:0] != 32'd0) |-> m_tuser[1:0] == ST_OK)
		else $error("popped value with error status");

	// A compare that finds the stacks equal never reports an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
		else $error("stacks_equal set with error status");

	// A stack never holds more than its capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> int'(m_tdata[39:32]) <= STACK_DEPTH)
		else $error("depth beyond capacity");

	// The block takes no new word in the cycle right after one was accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while one is at work");

endmodule

bind dual_stack_engine dse_chk u_dse_chk (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import dse_pkg::*;

	localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd5;
	localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd6;
	localparam logic [ACT_W-1:0] ACT_RSVD_C = 3'd7;
	localparam logic SEL_FIRST = 1'b0;
	localparam logic SEL_SECOND = 1'b1;
	localparam int RANDOM_ITEMS = 1550;
	localparam int PHASES = 4;
	// Longest walk is a remove over a full stack, which searches every entry and then moves the rest.
	localparam int DRAIN_CYCLES = 600;

	typedef struct packed {
		logic [DATA_W-1:0]  popped;
		status_t            status;
		logic               equal;
		logic [DEPTH_W-1:0] depth;
	} reply_t;

	class stack_scoreboard;
		logic [DATA_W-1:0] entries [2][STACK_DEPTH];
		int unsigned fill [2];
		reply_t pending [$];
		int errors;

		function new();
			fill[0] = 0;
			fill[1] = 0;
			errors = 0;
		endfunction

		function void note_request(logic [ACT_W-1:0] act, logic sel, logic [DATA_W-1:0] val);
			int unsigned n, lo, hi, i, pos;
			logic [DATA_W-1:0] t;
			bit found;
			reply_t r;
			r = '0;
			r.status = ST_OK;
			n = fill[sel];
			case (act)
				ACT_PUSH: begin
					if (n >= STACK_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						entries[sel][n] = val;
						n++;
					end
				end
				ACT_POP: begin
					if (n == 0) begin
						r.status = ST_EMPTY;
					end else begin
						n--;
						r.popped = entries[sel][n];
					end
				end
				ACT_REVERSE: begin
					if (n > 1) begin
						lo = 0;
						hi = n - 1;
						while (lo < hi) begin
							t = entries[sel][lo];
							entries[sel][lo] = entries[sel][hi];
							entries[sel][hi] = t;
							lo++;
							hi--;
						end
					end
				end
				ACT_REMOVE: begin
					// Search from the top down to and including the bottom entry.
					found = 0;
					i = n;
					while (i > 0 && !found) begin
						if (entries[sel][i-1] == val)
							found = 1;
						else
							i--;
					end
					if (!found) begin
						r.status = ST_NOTFOUND;
					end else begin
						for (pos = i - 1; pos + 1 < n; pos++)
							entries[sel][pos] = entries[sel][pos+1];
						n--;
					end
				end
				ACT_COMPARE: begin
					r.equal = (fill[0] == fill[1]);
					for (i = 0; i < fill[0]; i++)
						if (entries[0][i] != entries[1][i])
							r.equal = 1'b0;
				end
				default: ;
			endcase
			fill[sel] = n;
			r.depth = DEPTH_W'((act == ACT_COMPARE) ? fill[0] : n);
			pending.push_back(r);
		endfunction

		function void check_result(logic [TDATA_OUT_W-1:0] tdata, logic [TUSER_OUT_W-1:0] tuser);
			reply_t e;
			if (pending.size() == 0) begin
				$error("result word with no request waiting: tdata %h tuser %h", tdata, tuser);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (tdata[31:0] !== e.popped) begin
				$error("popped_value: expected %h, got %h", e.popped, tdata[31:0]);
				errors++;
			end
			if (tdata[39:32] !== e.depth) begin
				$error("depth_after: expected %0d, got %0d", e.depth, tdata[39:32]);
				errors++;
			end
			if (tuser[1:0] !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, tuser[1:0]);
				errors++;
			end
			if (tuser[2] !== e.equal) begin
				$error("stacks_equal: expected %0d, got %0d", e.equal, tuser[2]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_IN_W-1:0] s_tdata = '0;
	logic [TUSER_IN_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic [TUSER_OUT_W-1:0] m_tuser;

	stack_scoreboard board = new();
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int items_sent = 0;
	int idle_by_phase [PHASES] = '{0, 56, 0, 33};
	int stall_by_phase [PHASES] = '{0, 0, 56, 33};

	dual_stack_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	task automatic send_word(input logic [ACT_W-1:0] act, input logic sel,
			input logic [DATA_W-1:0] val);
		// Idle cycles carry junk on the bus so a word is only taken with tvalid.
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			s_tuser <= TUSER_IN_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= {sel, act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(act, sel, val);
		items_sent++;
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom_range(0, 3) - 1;
		if (r < 50) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	task automatic random_request();
		logic sel;
		int n, r, push_w;
		logic [DATA_W-1:0] v;
		sel = 1'($urandom_range(0, 1));
		n = board.fill[sel];
		// Keep the stacks shallow most of the time; the walks grow with depth.
		push_w = (n < 12) ? 45 : 20;
		r = $urandom_range(0, 99);
		if (r < push_w) begin
			send_word(ACT_PUSH, sel, pick_value());
		end else if (r < push_w + 20) begin
			send_word(ACT_POP, sel, $urandom);
		end else if (r < push_w + 30) begin
			send_word(ACT_REVERSE, sel, $urandom);
		end else if (r < push_w + 45) begin
			if (n > 0 && $urandom_range(0, 99) < 70)
				v = board.entries[sel][$urandom_range(0, n - 1)];
			else
				v = pick_value();
			send_word(ACT_REMOVE, sel, v);
		end else if (r < push_w + 53) begin
			send_word(ACT_COMPARE, sel, $urandom);
		end else if (r < push_w + 56) begin
			send_word(ACT_W'($urandom_range(ACT_RSVD_A, ACT_RSVD_C)), sel, $urandom);
		end else begin
			send_word(ACT_POP, sel, $urandom);
		end
	endtask

	// Builds two identical stacks, then compares them through reversals and edits.
	task automatic mirror_burst();
		int k;
		logic [DATA_W-1:0] v;
		while (board.fill[0] > 0)
			send_word(ACT_POP, SEL_FIRST, $urandom);
		while (board.fill[1] > 0)
			send_word(ACT_POP, SEL_SECOND, $urandom);
		k = $urandom_range(0, 6);
		repeat (k) begin
			v = pick_value();
			send_word(ACT_PUSH, SEL_FIRST, v);
			send_word(ACT_PUSH, SEL_SECOND, v);
		end
		send_word(ACT_COMPARE, 1'($urandom_range(0, 1)), $urandom);
		if ($urandom_range(0, 1)) begin
			send_word(ACT_REVERSE, SEL_FIRST, $urandom);
			send_word(ACT_REVERSE, SEL_SECOND, $urandom);
			send_word(ACT_COMPARE, 1'($urandom_range(0, 1)), $urandom);
		end
		send_word(ACT_REVERSE, 1'($urandom_range(0, 1)), $urandom);
		send_word(ACT_COMPARE, 1'($urandom_range(0, 1)), $urandom);
		send_word(ACT_REMOVE, 1'($urandom_range(0, 1)), pick_value());
		send_word(ACT_COMPARE, 1'($urandom_range(0, 1)), $urandom);
	endtask

	task automatic fill_and_drain(input logic sel);
		logic [DATA_W-1:0] marker;
		marker = 32'h5A5A_A5A5;
		while (board.fill[sel] < STACK_DEPTH - 1)
			send_word(ACT_PUSH, sel, pick_value());
		send_word(ACT_PUSH, sel, marker);
		send_word(ACT_PUSH, sel, $urandom);
		send_word(ACT_PUSH, sel, $urandom);
		// After the flip the marker sits at the bottom, so the search covers the whole stack.
		send_word(ACT_REVERSE, sel, $urandom);
		send_word(ACT_REMOVE, sel, marker);
		send_word(ACT_REMOVE, sel, marker);
		send_word(ACT_PUSH, sel, pick_value());
		send_word(ACT_COMPARE, sel, $urandom);
		send_word(ACT_REVERSE, sel, $urandom);
		while (board.fill[sel] > 4)
			send_word(ACT_POP, sel, $urandom);
	endtask

	initial begin
		int phase, phase_end;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ACT_COMPARE, SEL_SECOND, 32'h0000_0000);
		send_word(ACT_POP, SEL_FIRST, 32'hFFFF_FFFF);
		send_word(ACT_POP, SEL_SECOND, 32'h0000_0000);
		send_word(ACT_REVERSE, SEL_FIRST, 32'h0000_0000);
		send_word(ACT_REMOVE, SEL_SECOND, 32'h0000_0000);
		send_word(ACT_PUSH, SEL_FIRST, 32'h8000_0000);
		send_word(ACT_REVERSE, SEL_FIRST, 32'h7FFF_FFFF);
		send_word(ACT_PUSH, SEL_FIRST, 32'h7FFF_FFFF);
		send_word(ACT_PUSH, SEL_FIRST, 32'h0000_0000);
		send_word(ACT_PUSH, SEL_FIRST, 32'hFFFF_FFFF);
		send_word(ACT_PUSH, SEL_SECOND, 32'h5555_5555);
		send_word(ACT_PUSH, SEL_SECOND, 32'hAAAA_AAAA);
		send_word(ACT_PUSH, SEL_SECOND, 32'h5555_5555);
		send_word(ACT_REMOVE, SEL_SECOND, 32'h5555_5555);
		send_word(ACT_COMPARE, SEL_FIRST, 32'hAAAA_AAAA);
		send_word(ACT_REVERSE, SEL_FIRST, 32'h5555_5555);
		send_word(ACT_REMOVE, SEL_FIRST, 32'h7FFF_FFFF);
		send_word(ACT_REMOVE, SEL_FIRST, 32'h1234_5678);
		send_word(ACT_REMOVE, SEL_FIRST, 32'hFFFF_FFFF);
		send_word(ACT_POP, SEL_FIRST, 32'h0000_0000);
		send_word(ACT_RSVD_A, SEL_FIRST, 32'h0000_0000);
		send_word(ACT_RSVD_B, SEL_SECOND, 32'hAAAA_AAAA);
		send_word(ACT_RSVD_C, SEL_SECOND, 32'h5555_5555);
		send_word(ACT_POP, SEL_SECOND, 32'hFFFF_FFFF);
		send_word(ACT_POP, SEL_SECOND, 32'h8000_0000);

		for (phase = 0; phase < PHASES; phase++) begin
			sender_idle_pct = idle_by_phase[phase];
			receiver_stall_pct = stall_by_phase[phase];
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			if (phase == 0)
				fill_and_drain(SEL_FIRST);
			if (phase == 2)
				fill_and_drain(SEL_SECOND);
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 99) < 15)
					mirror_burst();
				else
					repeat (20) random_request();
			end
		end
		s_tvalid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
